@@ design/jips_pkg.sv @@
// ----------------------------------------------------------------------------
// jips_pkg: joint impedance plant step shared definitions
// Number formats, control word layout and the step program of the sequencer.
// ----------------------------------------------------------------------------
package jips_pkg;

	localparam int DATA_W    = 32;
	localparam int GAIN_W    = 31;
	localparam int DT_W      = 16;
	localparam int JOINT_W   = 4;
	localparam int HIT_W     = 2;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int FRAC_BITS = 16;
	localparam int DT_FRAC   = 16;

	localparam logic [DT_W-1:0] DT_MIN = 16'd7;

	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	localparam int PROG_LEN = 12;
	localparam int PC_W     = $clog2(PROG_LEN);

	typedef logic signed [DATA_W-1:0] q_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef enum logic [HIT_W-1:0] {
		HIT_NONE = 2'd0,
		HIT_MIN  = 2'd1,
		HIT_MAX  = 2'd2
	} hit_t;

	// multiplier operand selects
	typedef enum logic [2:0] {MA_KP, MA_KD, MA_FRIC, MA_TRQ, MA_MQ, MA_VN} mua_t;
	typedef enum logic [2:0] {MB_ERR, MB_VERR, MB_VEL, MB_INV, MB_DT} mub_t;

	// saturating adder operand selects and destinations
	typedef enum logic [2:0] {AA_TGT, AA_TGTV, AA_M1, AA_TRQ, AA_VEL, AA_POS} alua_t;
	typedef enum logic [2:0] {AB_POS, AB_VEL, AB_MQ, AB_FF, AB_FRIC} alub_t;
	typedef enum logic [2:0] {D_NONE, D_ERR, D_VERR, D_TRQ, D_VN, D_PN} dst_t;

	// capture of the scaled product into a holding register
	typedef enum logic [1:0] {C_NONE, C_FRIC, C_M1} cap_t;

	// sequencing: advance, or hold until the output register is free and finish
	typedef enum logic {SQ_NEXT, SQ_DONE} seq_t;

	typedef struct packed {
		mua_t  mul_a;
		mub_t  mul_b;
		logic  mul_dt;
		alua_t alu_a;
		alub_t alu_b;
		logic  alu_sub;
		dst_t  alu_dst;
		cap_t  cap;
		seq_t  seq;
	} ctl_t;

	localparam ctl_t CTL_NOP = '{
		mul_a: MA_KP, mul_b: MB_ERR, mul_dt: 1'b0,
		alu_a: AA_TGT, alu_b: AB_POS, alu_sub: 1'b0, alu_dst: D_NONE,
		cap: C_NONE, seq: SQ_NEXT
	};

	// step program: one control word per step
	function automatic ctl_t prog_rom(input logic [PC_W-1:0] pc);
		ctl_t c;
		c = CTL_NOP;
		unique case (pc)
			4'd0: begin
				c.mul_a = MA_FRIC; c.mul_b = MB_VEL;
				c.alu_a = AA_TGT; c.alu_b = AB_POS; c.alu_sub = 1'b1; c.alu_dst = D_ERR;
			end
			4'd1: begin
				c.mul_a = MA_KP; c.mul_b = MB_ERR;
				c.alu_a = AA_TGTV; c.alu_b = AB_VEL; c.alu_sub = 1'b1; c.alu_dst = D_VERR;
				c.cap = C_FRIC;
			end
			4'd2: begin
				c.mul_a = MA_KD; c.mul_b = MB_VERR;
				c.cap = C_M1;
			end
			4'd3: begin
				c.alu_a = AA_M1; c.alu_b = AB_MQ; c.alu_dst = D_TRQ;
			end
			4'd4: begin
				c.alu_a = AA_TRQ; c.alu_b = AB_FF; c.alu_dst = D_TRQ;
			end
			4'd5: begin
				c.alu_a = AA_TRQ; c.alu_b = AB_FRIC; c.alu_sub = 1'b1; c.alu_dst = D_TRQ;
			end
			4'd6: begin
				c.mul_a = MA_TRQ; c.mul_b = MB_INV;
			end
			4'd7: begin
				c.mul_a = MA_MQ; c.mul_b = MB_DT; c.mul_dt = 1'b1;
			end
			4'd8: begin
				c.alu_a = AA_VEL; c.alu_b = AB_MQ; c.alu_dst = D_VN;
			end
			4'd9: begin
				c.mul_a = MA_VN; c.mul_b = MB_DT; c.mul_dt = 1'b1;
			end
			4'd10: begin
				c.alu_a = AA_POS; c.alu_b = AB_MQ; c.alu_dst = D_PN;
			end
			default: begin
				c.seq = SQ_DONE;
			end
		endcase
		return c;
	endfunction

	function automatic q_t sat32(input prod_t x);
		q_t r;
		if (x > PROD_W'(Q_MAX))
			r = Q_MAX;
		else if (x < PROD_W'(Q_MIN))
			r = Q_MIN;
		else
			r = q_t'(x);
		return r;
	endfunction

	function automatic q_t sat_add(input q_t a, input q_t b, input logic sub);
		logic signed [DATA_W:0] s;
		q_t r;
		s = sub ? ((DATA_W+1)'(a) - (DATA_W+1)'(b)) : ((DATA_W+1)'(a) + (DATA_W+1)'(b));
		if (s > (DATA_W+1)'(Q_MAX))
			r = Q_MAX;
		else if (s < (DATA_W+1)'(Q_MIN))
			r = Q_MIN;
		else
			r = q_t'(s);
		return r;
	endfunction

endpackage

@@ design/joint_impedance_plant_step.sv @@
// ----------------------------------------------------------------------------
// joint_impedance_plant_step: one simulated joint step per input word
// PD impedance torque, semi-implicit Euler update and joint limit clamp,
// run by a small microcoded sequencer over one multiplier and one adder.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one word: joint index, targets,
//   gains, feedforward, time step and plant constants. output channel
//   (out_valid / out_stall) returns one word per input word: joint, new
//   position and velocity, torque and the limit code.
//   a word is taken while in_stall is low; in_stall stays high while the 12
//   steps of the program run, so a new word is taken only once the last one
//   has finished its steps. the step count is set by the single shared
//   multiplier: six dependent products, each registered before use, plus the
//   adder steps between them. the result sits in an output register, so the
//   next input word is taken while a finished result waits; only the finishing
//   step of the next word holds until that result has gone.
//   per joint position and velocity live in two small memories; a per-entry
//   valid bit, cleared by reset, makes an unwritten joint read as zero, so the
//   block takes words right out of reset. joint indexes at or above
//   NUM_JOINTS step from zero and store nothing.
// ----------------------------------------------------------------------------
module joint_impedance_plant_step #(
	parameter int NUM_JOINTS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic        [jips_pkg::JOINT_W-1:0] joint_index,
	input  logic signed [jips_pkg::DATA_W-1:0]  position_target,
	input  logic signed [jips_pkg::DATA_W-1:0]  velocity_target,
	input  logic        [jips_pkg::GAIN_W-1:0]  stiffness_gain,
	input  logic        [jips_pkg::GAIN_W-1:0]  damping_gain,
	input  logic signed [jips_pkg::DATA_W-1:0]  feedforward_torque,
	input  logic        [jips_pkg::DT_W-1:0]    time_step,
	input  logic        [jips_pkg::GAIN_W-1:0]  inverse_inertia,
	input  logic        [jips_pkg::GAIN_W-1:0]  plant_damping,
	input  logic signed [jips_pkg::DATA_W-1:0]  position_min,
	input  logic signed [jips_pkg::DATA_W-1:0]  position_max,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic        [jips_pkg::JOINT_W-1:0] joint_out,
	output logic signed [jips_pkg::DATA_W-1:0]  position,
	output logic signed [jips_pkg::DATA_W-1:0]  velocity,
	output logic signed [jips_pkg::DATA_W-1:0]  effort,
	output logic        [jips_pkg::HIT_W-1:0]   limit_hit
);

	import jips_pkg::*;

	localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

	// control state
	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic            out_valid_q;
	logic [NUM_JOINTS-1:0] vbit_q;

	// latched input word
	logic [JOINT_W-1:0] idx_q;
	logic [AW-1:0]      addr_q;
	logic               ok_q;
	q_t                 tgt_q, tgtv_q, ff_q, pmin_q, pmax_q;
	logic [GAIN_W-1:0]  kp_q, kd_q, inv_q, fric_q;
	logic [DT_W-1:0]    dt_q;

	// joint store and its registered read
	q_t   mem_pos_q [NUM_JOINTS];
	q_t   mem_vel_q [NUM_JOINTS];
	q_t   rd_pos_q, rd_vel_q;
	logic rd_ok_q;

	// datapath registers
	prod_t prod_q;
	logic  prod_dt_q;
	q_t    err_q, verr_q, trq_q, vn_q, pn_q, fterm_q, m1_q;

	// output register
	logic [JOINT_W-1:0] joint_q;
	q_t                 position_q, velocity_q, effort_q;
	hit_t               hit_q;

	ctl_t        ctl;
	logic        in_acc, out_acc, out_free, done_w, idx_ok_w;
	logic [AW-1:0] addr_w;
	q_t          pos_w, vel_w, mq_w, mul_a_w, mul_b_w, alu_a_w, alu_b_w, alu_w;
	q_t          p1_w, v1_w, p2_w, v2_w;
	hit_t        h1_w, h2_w;

	assign ctl      = prog_rom(pc_q);
	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	// finishing step: clamp, write back, load the output register
	assign done_w   = busy_q && (ctl.seq == SQ_DONE) && out_free;

	assign idx_ok_w = (32'(joint_index) < NUM_JOINTS);
	assign addr_w   = AW'(joint_index);

	// unwritten or out of range joints start from rest at zero
	assign pos_w = rd_ok_q ? rd_pos_q : '0;
	assign vel_w = rd_ok_q ? rd_vel_q : '0;

	// scaled product of the previous step, floor shift then saturate
	assign mq_w = sat32(prod_dt_q ? (prod_q >>> DT_FRAC) : (prod_q >>> FRAC_BITS));

	always_comb begin
		unique case (ctl.mul_a)
			MA_KP:   mul_a_w = signed'({1'b0, kp_q});
			MA_KD:   mul_a_w = signed'({1'b0, kd_q});
			MA_FRIC: mul_a_w = signed'({1'b0, fric_q});
			MA_TRQ:  mul_a_w = trq_q;
			MA_MQ:   mul_a_w = mq_w;
			MA_VN:   mul_a_w = vn_q;
			default: mul_a_w = '0;
		endcase
		unique case (ctl.mul_b)
			MB_ERR:  mul_b_w = err_q;
			MB_VERR: mul_b_w = verr_q;
			MB_VEL:  mul_b_w = vel_w;
			MB_INV:  mul_b_w = signed'({1'b0, inv_q});
			MB_DT:   mul_b_w = signed'({{(DATA_W-DT_W){1'b0}}, dt_q});
			default: mul_b_w = '0;
		endcase
		unique case (ctl.alu_a)
			AA_TGT:  alu_a_w = tgt_q;
			AA_TGTV: alu_a_w = tgtv_q;
			AA_M1:   alu_a_w = m1_q;
			AA_TRQ:  alu_a_w = trq_q;
			AA_VEL:  alu_a_w = vel_w;
			AA_POS:  alu_a_w = pos_w;
			default: alu_a_w = '0;
		endcase
		unique case (ctl.alu_b)
			AB_POS:  alu_b_w = pos_w;
			AB_VEL:  alu_b_w = vel_w;
			AB_MQ:   alu_b_w = mq_w;
			AB_FF:   alu_b_w = ff_q;
			AB_FRIC: alu_b_w = fterm_q;
			default: alu_b_w = '0;
		endcase
	end

	assign alu_w = sat_add(alu_a_w, alu_b_w, ctl.alu_sub);

	// limit handling: the minimum check first, the maximum check wins
	always_comb begin
		if (pn_q < pmin_q) begin
			p1_w = pmin_q;
			v1_w = (vn_q < 0) ? '0 : vn_q;
			h1_w = HIT_MIN;
		end else begin
			p1_w = pn_q;
			v1_w = vn_q;
			h1_w = HIT_NONE;
		end
		if (p1_w > pmax_q) begin
			p2_w = pmax_q;
			v2_w = (v1_w > 0) ? '0 : v1_w;
			h2_w = HIT_MAX;
		end else begin
			p2_w = p1_w;
			v2_w = v1_w;
			h2_w = h1_w;
		end
	end

	// sequencer, handshake state and valid bits of the joint store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
			vbit_q      <= '0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end else if (busy_q) begin
				unique case (ctl.seq)
					SQ_NEXT: pc_q <= pc_q + 1'b1;
					SQ_DONE: if (out_free) busy_q <= 1'b0;
				endcase
			end
			if (done_w)
				out_valid_q <= 1'b1;
			else if (out_acc)
				out_valid_q <= 1'b0;
			if (done_w && ok_q)
				vbit_q[addr_q] <= 1'b1;
		end
	end

	// input word capture and store read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q    <= joint_index;
			addr_q   <= addr_w;
			ok_q     <= idx_ok_w;
			tgt_q    <= position_target;
			tgtv_q   <= velocity_target;
			kp_q     <= stiffness_gain;
			kd_q     <= damping_gain;
			ff_q     <= feedforward_torque;
			dt_q     <= (time_step < DT_MIN) ? DT_MIN : time_step;
			inv_q    <= inverse_inertia;
			fric_q   <= plant_damping;
			pmin_q   <= position_min;
			pmax_q   <= position_max;
			rd_pos_q <= mem_pos_q[addr_w];
			rd_vel_q <= mem_vel_q[addr_w];
			rd_ok_q  <= idx_ok_w && vbit_q[addr_w];
		end
	end

	// store write back
	always_ff @(posedge clk) begin
		if (done_w && ok_q) begin
			mem_pos_q[addr_q] <= p2_w;
			mem_vel_q[addr_q] <= v2_w;
		end
	end

	// datapath: multiplier register, adder destinations, captures
	always_ff @(posedge clk) begin
		prod_q    <= PROD_W'(mul_a_w) * PROD_W'(mul_b_w);
		prod_dt_q <= ctl.mul_dt;
		if (busy_q) begin
			unique case (ctl.alu_dst)
				D_NONE: ;
				D_ERR:  err_q  <= alu_w;
				D_VERR: verr_q <= alu_w;
				D_TRQ:  trq_q  <= alu_w;
				D_VN:   vn_q   <= alu_w;
				D_PN:   pn_q   <= alu_w;
				default: ;
			endcase
			unique case (ctl.cap)
				C_NONE: ;
				C_FRIC: fterm_q <= mq_w;
				C_M1:   m1_q    <= mq_w;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (done_w) begin
			joint_q    <= idx_q;
			position_q <= p2_w;
			velocity_q <= v2_w;
			effort_q   <= trq_q;
			hit_q      <= h2_w;
		end
	end

	assign out_valid = out_valid_q;
	assign joint_out = joint_q;
	assign position  = position_q;
	assign velocity  = velocity_q;
	assign effort    = effort_q;
	assign limit_hit = hit_q;

endmodule

@@ design/jips_checker.sv @@
// ----------------------------------------------------------------------------
// jips_checker: port level checks of the joint impedance plant step
// Watches the handshake and the limit code against the reported velocity.
// ----------------------------------------------------------------------------
module jips_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic        [jips_pkg::JOINT_W-1:0] joint_out,
	input logic signed [jips_pkg::DATA_W-1:0]  position,
	input logic signed [jips_pkg::DATA_W-1:0]  velocity,
	input logic signed [jips_pkg::DATA_W-1:0]  effort,
	input logic        [jips_pkg::HIT_W-1:0]   limit_hit
);

	import jips_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(joint_out) && $stable(position)
			&& $stable(velocity) && $stable(effort) && $stable(limit_hit))
		else $error("result word changed while stalled");

	// no result appears unless a word was in work
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |=> !$rose(out_valid))
		else $error("result word without a word in work");

	// only the three limit codes
	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> limit_hit == HIT_NONE || limit_hit == HIT_MIN || limit_hit == HIT_MAX)
		else $error("bad limit code");

	// clamped at minimum: no velocity pointing further down
	a_min_vel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limit_hit == HIT_MIN |-> !velocity[DATA_W-1])
		else $error("negative velocity at lower limit");

	// clamped at maximum: no velocity pointing further up
	a_max_vel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limit_hit == HIT_MAX |-> velocity[DATA_W-1] || velocity == '0)
		else $error("positive velocity at upper limit");

endmodule

bind joint_impedance_plant_step jips_checker u_jips_checker (.*);
